// ===== design/aad_pkg.sv =====
// ----------------------------------------------------------------------------
// aad_pkg: shared types, constants and helpers for the aim angle delta core
// Holds the CORDIC step table, the angle constants and the turn wrap helper.
// ----------------------------------------------------------------------------
package aad_pkg;

  // Field widths of the item ports.
  localparam int IN_W    = 24;
  localparam int ANGLE_W = 16;

  // Defaults for the top-level parameters, and the cap on CORDIC stages.
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int COORD_WIDTH_DEF   = 24;
  localparam int MAX_STAGES        = 24;

  // Angle accumulator in 1/32768 degree, angles in 1/128 degree.
  localparam int ACC_W   = 25;
  localparam int UNIT_W  = 17;
  localparam int DELTA_W = 18;

  localparam logic signed [ACC_W-1:0] DEG90_Q8  = ACC_W'(2949120);
  localparam logic signed [ACC_W-1:0] DEG180_Q8 = ACC_W'(5898240);
  localparam int HALF_TURN = 23040;
  localparam int FULL_TURN = 46080;
  localparam int KINV_Q16  = 39797;
  localparam int KINV_W    = 16;

  // Control that travels with each item through the CORDIC row.
  typedef struct packed {
    logic valid;
    logic y_zero;
    logic y_pos;
    logic x_zero;
    logic x_neg;
  } aad_ctl_t;

  // atan(2^-i) in 1/32768 degree, rounded to nearest.
  function automatic logic [21:0] step_q8(input int i);
    logic [21:0] s;
    begin
      unique case (i)
        0:  s = 22'd1474560;
        1:  s = 22'd870484;
        2:  s = 22'd459940;
        3:  s = 22'd233473;
        4:  s = 22'd117189;
        5:  s = 22'd58652;
        6:  s = 22'd29333;
        7:  s = 22'd14667;
        8:  s = 22'd7334;
        9:  s = 22'd3667;
        10: s = 22'd1833;
        11: s = 22'd917;
        12: s = 22'd458;
        13: s = 22'd229;
        14: s = 22'd115;
        15: s = 22'd57;
        16: s = 22'd29;
        17: s = 22'd14;
        18: s = 22'd7;
        19: s = 22'd4;
        20: s = 22'd2;
        21: s = 22'd1;
        default: s = 22'd0;
      endcase
      return s;
    end
  endfunction

  // Wraps a difference into [-180, 180] degrees. An exact half turn goes to
  // the sign that makes the removed multiple of a full turn even.
  function automatic logic signed [ANGLE_W-1:0] wrap_turn(
      input logic signed [DELTA_W-1:0] d);
    logic signed [DELTA_W+1:0] t;
    logic signed [DELTA_W+1:0] r;
    logic odd;
    begin
      t   = (DELTA_W+2)'(d) + (DELTA_W+2)'(2 * FULL_TURN);
      r   = t;
      odd = 1'b0;
      for (int m = 0; m < 5; m++) begin
        if (t >= (DELTA_W+2)'(m * FULL_TURN) && t < (DELTA_W+2)'((m + 1) * FULL_TURN)) begin
          r   = t - (DELTA_W+2)'(m * FULL_TURN);
          odd = m[0];
        end
      end
      if (r > (DELTA_W+2)'(HALF_TURN)) begin
        return ANGLE_W'(r - (DELTA_W+2)'(FULL_TURN));
      end else if (r < (DELTA_W+2)'(HALF_TURN)) begin
        return ANGLE_W'(r);
      end
      return odd ? ANGLE_W'(-HALF_TURN) : ANGLE_W'(HALF_TURN);
    end
  endfunction

endpackage

// ===== design/aad_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// aad_cordic_cell: one CORDIC vectoring iteration
// Rotates (x, y) toward the x axis by atan(2^-IDX) and registers the result.
// ----------------------------------------------------------------------------
module aad_cordic_cell #(
  parameter int XW  = 36,
  parameter int SW  = 8,
  parameter int IDX = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  aad_pkg::aad_ctl_t                 in_ctl,
  input  logic signed [XW-1:0]              in_x,
  input  logic signed [XW-1:0]              in_y,
  input  logic signed [aad_pkg::ACC_W-1:0]  in_acc,
  input  logic [SW-1:0]                     in_side,
  output aad_pkg::aad_ctl_t                 out_ctl,
  output logic signed [XW-1:0]              out_x,
  output logic signed [XW-1:0]              out_y,
  output logic signed [aad_pkg::ACC_W-1:0]  out_acc,
  output logic [SW-1:0]                     out_side
);

  localparam logic signed [aad_pkg::ACC_W-1:0] STEP =
    aad_pkg::ACC_W'(aad_pkg::step_q8(IDX));

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  // Arithmetic shifts floor toward minus infinity.
  assign xs = in_x >>> IDX;
  assign ys = in_y >>> IDX;

  // Control: only the valid flag needs a reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= in_ctl;
    end
  end

  // Rotate by the sign of y.
  always_ff @(posedge clk) begin
    out_side <= in_side;
    if (in_y > 0) begin
      out_x   <= in_x + ys;
      out_y   <= in_y - xs;
      out_acc <= in_acc + STEP;
    end else begin
      out_x   <= in_x - ys;
      out_y   <= in_y + xs;
      out_acc <= in_acc - STEP;
    end
  end

endmodule

// ===== design/aad_vector_unit.sv =====
// ----------------------------------------------------------------------------
// aad_vector_unit: pipelined CORDIC vectoring unit
// Quadrant pre-rotation, a row of iteration cells, then axis handling and
// rounding of the angle to 1/128 degree.
// ----------------------------------------------------------------------------
module aad_vector_unit #(
  parameter int XW     = 36,
  parameter int SW     = 8,
  parameter int STAGES = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic signed [XW-1:0]               in_x,
  input  logic signed [XW-1:0]               in_y,
  input  logic [SW-1:0]                      in_side,
  output logic                               out_valid,
  output logic signed [aad_pkg::UNIT_W-1:0]  out_angle,
  output logic signed [XW-1:0]               out_mag,
  output logic [SW-1:0]                      out_side
);

  localparam int N = (STAGES > aad_pkg::MAX_STAGES) ? aad_pkg::MAX_STAGES : STAGES;
  localparam int AW = aad_pkg::ACC_W;

  aad_pkg::aad_ctl_t         ctl  [N+1];
  logic signed [XW-1:0]      cx   [N+1];
  logic signed [XW-1:0]      cy   [N+1];
  logic signed [AW-1:0]      acc  [N+1];
  logic [SW-1:0]             side [N+1];

  aad_pkg::aad_ctl_t         ctl_in;
  logic signed [AW-1:0]      acc_fin;
  logic signed [AW:0]        acc_rnd;

  // Flags of the original vector for the axis cases.
  always_comb begin
    ctl_in.valid  = in_valid;
    ctl_in.y_zero = (in_y == '0);
    ctl_in.y_pos  = (in_y > 0);
    ctl_in.x_zero = (in_x == '0);
    ctl_in.x_neg  = in_x[XW-1];
  end

  // Entry stage: bring x to the right half plane.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else begin
      ctl[0] <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    side[0] <= in_side;
    if (in_x[XW-1]) begin
      if (!in_y[XW-1]) begin
        cx[0]  <= in_y;
        cy[0]  <= -in_x;
        acc[0] <= aad_pkg::DEG90_Q8;
      end else begin
        cx[0]  <= -in_y;
        cy[0]  <= in_x;
        acc[0] <= -aad_pkg::DEG90_Q8;
      end
    end else begin
      cx[0]  <= in_x;
      cy[0]  <= in_y;
      acc[0] <= '0;
    end
  end

  // Row of iteration cells.
  for (genvar i = 0; i < N; i++) begin : g_cell
    aad_cordic_cell #(
      .XW  (XW),
      .SW  (SW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_ctl   (ctl[i]),
      .in_x     (cx[i]),
      .in_y     (cy[i]),
      .in_acc   (acc[i]),
      .in_side  (side[i]),
      .out_ctl  (ctl[i+1]),
      .out_x    (cx[i+1]),
      .out_y    (cy[i+1]),
      .out_acc  (acc[i+1]),
      .out_side (side[i+1])
    );
  end

  // Axis vectors get exact angles.
  always_comb begin
    priority if (ctl[N].y_zero) begin
      acc_fin = ctl[N].x_neg ? aad_pkg::DEG180_Q8 : '0;
    end else if (ctl[N].x_zero) begin
      acc_fin = ctl[N].y_pos ? aad_pkg::DEG90_Q8 : -aad_pkg::DEG90_Q8;
    end else begin
      acc_fin = acc[N];
    end
    acc_rnd = (AW+1)'(acc_fin) + (AW+1)'(128);
  end

  // Output stage: round to 1/128 degree.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctl[N].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_angle <= aad_pkg::UNIT_W'(acc_rnd >>> 8);
    out_mag   <= cx[N];
    out_side  <= side[N];
  end

endmodule

// ===== design/aim_angle_delta_core.sv =====
// ----------------------------------------------------------------------------
// aim_angle_delta_core: pitch and yaw correction toward a target point
// Forms end - start, finds yaw and pitch by two CORDIC vectoring rows and
// returns both differences to the current angles, wrapped to a half turn.
// ----------------------------------------------------------------------------
// The core takes one item in every clock cycle; busy is always low. Each item
// gives exactly one result, marked by done for one cycle. The path runs
// through the input stage, the yaw CORDIC row (entry stage, one cell per
// iteration, rounding stage), the two-stage horizontal length scaling, the
// pitch row built the same way, then the difference and wrap stages. The
// receiver cannot stall, so results must be taken as they appear.
module aim_angle_delta_core #(
  parameter int CORDIC_STAGES = aad_pkg::CORDIC_STAGES_DEF,
  parameter int COORD_WIDTH   = aad_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [aad_pkg::IN_W-1:0]     start_x,
  input  logic signed [aad_pkg::IN_W-1:0]     start_y,
  input  logic signed [aad_pkg::IN_W-1:0]     start_z,
  input  logic signed [aad_pkg::IN_W-1:0]     end_x,
  input  logic signed [aad_pkg::IN_W-1:0]     end_y,
  input  logic signed [aad_pkg::IN_W-1:0]     end_z,
  input  logic signed [aad_pkg::ANGLE_W-1:0]  current_pitch,
  input  logic signed [aad_pkg::ANGLE_W-1:0]  current_yaw,
  output logic                                done,
  output logic signed [aad_pkg::ANGLE_W-1:0]  pitch_delta,
  output logic signed [aad_pkg::ANGLE_W-1:0]  yaw_delta
);

  localparam int W   = COORD_WIDTH;
  localparam int DW  = W + 1;
  localparam int XW  = W + 12;
  localparam int HW  = XW - aad_pkg::KINV_W;
  localparam int AGW = aad_pkg::ANGLE_W;
  localparam int UW  = aad_pkg::UNIT_W;
  localparam int DLW = aad_pkg::DELTA_W;
  localparam int N   = (CORDIC_STAGES > aad_pkg::MAX_STAGES) ?
                       aad_pkg::MAX_STAGES : CORDIC_STAGES;
  localparam int LAT = 2 * N + 9;
  localparam int YSW = DW + 2 * AGW;
  localparam int PSW = UW + 2 * AGW;

  // Coordinate from the low W bits of a field, as the difference width.
  function automatic logic signed [DW-1:0] coord(input logic [aad_pkg::IN_W-1:0] v);
    logic [31:0] raw;
    begin
      raw = 32'(v);
      return DW'(signed'(raw[W-1:0]));
    end
  endfunction

  logic                    s1_valid;
  logic signed [DW-1:0]    s1_dx;
  logic signed [DW-1:0]    s1_dy;
  logic signed [DW-1:0]    s1_dz;
  logic signed [AGW-1:0]   s1_cp;
  logic signed [AGW-1:0]   s1_cy;

  logic                    yu_valid;
  logic signed [UW-1:0]    yu_angle;
  logic signed [XW-1:0]    yu_mag;
  logic [YSW-1:0]          yu_side;

  logic                    m1_valid;
  logic [XW-1:0]           m1_hi;
  logic [31:0]             m1_lo;
  logic [YSW-1:0]          m1_side;
  logic signed [UW-1:0]    m1_yaw;
  logic [32:0]             lo_rnd;

  logic                    m2_valid;
  logic signed [XW-1:0]    m2_h;
  logic signed [XW-1:0]    m2_y;
  logic [PSW-1:0]          m2_side;
  logic signed [DW-1:0]    m1_dz;

  logic                    pu_valid;
  logic signed [UW-1:0]    pu_angle;
  logic [PSW-1:0]          pu_side;
  logic signed [UW-1:0]    pu_yaw;
  logic signed [AGW-1:0]   pu_cp;
  logic signed [AGW-1:0]   pu_cy;

  logic                    d_valid;
  logic signed [DLW-1:0]   d_pitch;
  logic signed [DLW-1:0]   d_yaw;

  // The core never holds off an item.
  assign busy = 1'b0;

  // Input stage: coordinate differences.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    s1_dx <= coord(end_x) - coord(start_x);
    s1_dy <= coord(end_y) - coord(start_y);
    s1_dz <= coord(end_z) - coord(start_z);
    s1_cp <= current_pitch;
    s1_cy <= current_yaw;
  end

  // Yaw row: angle of (dx, dy) with 8 guard bits.
  aad_vector_unit #(
    .XW     (XW),
    .SW     (YSW),
    .STAGES (N)
  ) u_yaw (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_x      (XW'(signed'({s1_dx, 8'd0}))),
    .in_y      (XW'(signed'({s1_dy, 8'd0}))),
    .in_side   ({s1_dz, s1_cp, s1_cy}),
    .out_valid (yu_valid),
    .out_angle (yu_angle),
    .out_mag   (yu_mag),
    .out_side  (yu_side)
  );

  // Gain correction, first stage: partial products of the magnitude.
  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else begin
      m1_valid <= yu_valid;
    end
  end

  always_ff @(posedge clk) begin
    m1_hi   <= XW'(yu_mag[XW-1:aad_pkg::KINV_W]) * XW'(aad_pkg::KINV_Q16);
    m1_lo   <= 32'(yu_mag[aad_pkg::KINV_W-1:0]) * 32'(aad_pkg::KINV_Q16);
    m1_side <= yu_side;
    m1_yaw  <= yu_angle;
  end

  // Gain correction, second stage: round the scaled length half up.
  assign lo_rnd = 33'(m1_lo) + 33'd32768;
  assign m1_dz  = m1_side[YSW-1 -: DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    m2_h    <= signed'(m1_hi + XW'(lo_rnd[32:16]));
    m2_y    <= -XW'(signed'({m1_dz, 8'd0}));
    m2_side <= {m1_yaw, m1_side[2*AGW-1:0]};
  end

  // Pitch row: angle of (horizontal length, -dz).
  aad_vector_unit #(
    .XW     (XW),
    .SW     (PSW),
    .STAGES (N)
  ) u_pitch (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m2_valid),
    .in_x      (m2_h),
    .in_y      (m2_y),
    .in_side   (m2_side),
    .out_valid (pu_valid),
    .out_angle (pu_angle),
    .out_mag   (),
    .out_side  (pu_side)
  );

  assign pu_yaw = pu_side[PSW-1 -: UW];
  assign pu_cp  = pu_side[2*AGW-1 -: AGW];
  assign pu_cy  = pu_side[AGW-1:0];

  // Differences to the current angles.
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= pu_valid;
    end
  end

  always_ff @(posedge clk) begin
    d_pitch <= DLW'(pu_angle) - DLW'(pu_cp);
    d_yaw   <= DLW'(pu_yaw) - DLW'(pu_cy);
  end

  // Output stage: wrap into a half turn.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    pitch_delta <= aad_pkg::wrap_turn(d_pitch);
    yaw_delta   <= aad_pkg::wrap_turn(d_yaw);
  end

`ifndef SYNTHESIS
  // A result only comes from an item taken earlier by start.
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a matching item");

  // Wrapped deltas stay within a half turn.
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (pitch_delta <= AGW'(aad_pkg::HALF_TURN) &&
              pitch_delta >= AGW'(-aad_pkg::HALF_TURN)))
    else $error("pitch delta out of range");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (yaw_delta <= AGW'(aad_pkg::HALF_TURN) &&
              yaw_delta >= AGW'(-aad_pkg::HALF_TURN)))
    else $error("yaw delta out of range");
`endif

endmodule
